>>> rtl/ott_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ott_pkg
// Shared types and constants for the outstanding transaction tracker.
// ----------------------------------------------------------------------------
package ott_pkg;

  localparam int TableDepth = 16;
  localparam int IdBits     = 32;
  localparam int TimeBits   = 32;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam logic [TimeBits-1:0] TimeoutReset = TimeBits'(1000);

  typedef enum logic [1:0] {
    REQ_POST     = 2'd0,
    REQ_COMPLETE = 2'd1,
    REQ_TICK     = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    STAT_POSTED    = 3'd0,
    STAT_COMPLETED = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_TIMED_OUT = 3'd3,
    STAT_IDLE      = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  typedef enum logic {
    CTRL_WAIT = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic exec;
  } ott_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } ott_stat_t;

endpackage
`default_nettype wire

>>> rtl/ott_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ott_ctrl
// Controller: takes one transaction, then runs it once the result slot frees.
// ----------------------------------------------------------------------------
module ott_ctrl import ott_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire ott_stat_t stat,
  output ott_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTRL_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CTRL_WAIT: if (s_tvalid) state_next = CTRL_EXEC;
      CTRL_EXEC: if (!stat.out_blocked) state_next = CTRL_WAIT;
      default:   state_next = CTRL_WAIT;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    cmd.latch = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state)
      CTRL_WAIT: begin
        s_tready  = 1'b1;
        cmd.latch = s_tvalid;
      end
      CTRL_EXEC: begin
        // hold while the previous result still waits
        cmd.exec = !stat.out_blocked;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ott_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ott_dp
// Datapath: ordered slot table, time counter, timeout register, result register.
// ----------------------------------------------------------------------------
module ott_dp import ott_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ott_cmd_t            cmd,
  output ott_stat_t                stat,
  input  wire logic [1:0]          in_req,
  input  wire logic [IdBits-1:0]   in_id,
  input  wire logic                cfg_valid,
  input  wire logic [TimeBits-1:0] cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_status,
  output logic [IdBits-1:0]        out_id
);

  logic [IdBits-1:0]   slot_id [TableDepth];
  logic [TimeBits-1:0] slot_deadline [TableDepth];
  logic [CntW-1:0]     count;
  logic [TimeBits-1:0] time_now;
  logic [TimeBits-1:0] timeout_ticks;
  req_t                req;
  logic [IdBits-1:0]   id;

  logic [TimeBits-1:0] time_inc;
  logic [TimeBits-1:0] diff;
  logic                expired;
  logic                full;
  logic [TableDepth-1:0] match;
  logic                found;
  logic [IdxW-1:0]     match_pos;
  logic                remove;
  logic [IdxW-1:0]     remove_pos;
  logic                do_post;
  logic                do_tick;
  status_t             res_status;
  logic [IdBits-1:0]   res_id;

  assign stat.out_blocked = out_valid && !out_ready;

  assign time_inc = time_now + TimeBits'(1);
  assign diff     = slot_deadline[0] - time_inc;
  assign expired  = (count != '0) && diff[TimeBits-1];
  assign full     = (count == CntW'(TableDepth));

  always_comb begin
    for (int k = 0; k < TableDepth; k++) begin
      match[k] = (CntW'(k) < count) && (slot_id[k] == id);
    end
  end

  // lowest matching slot is the oldest
  always_comb begin
    found     = 1'b0;
    match_pos = '0;
    for (int k = TableDepth - 1; k >= 0; k--) begin
      if (match[k]) begin
        found     = 1'b1;
        match_pos = IdxW'(k);
      end
    end
  end

  always_comb begin
    res_status = STAT_IDLE;
    res_id     = '0;
    remove     = 1'b0;
    remove_pos = '0;
    do_post    = 1'b0;
    do_tick    = 1'b0;
    unique case (req)
      REQ_POST: begin
        if (full) begin
          res_status = STAT_FULL;
        end else begin
          do_post    = 1'b1;
          res_status = STAT_POSTED;
          res_id     = id;
        end
      end
      REQ_COMPLETE: begin
        res_status = STAT_NOT_FOUND;
        if (found) begin
          remove     = 1'b1;
          remove_pos = match_pos;
          res_status = STAT_COMPLETED;
          res_id     = id;
        end
      end
      REQ_TICK: begin
        do_tick = 1'b1;
        if (expired) begin
          remove     = 1'b1;
          res_status = STAT_TIMED_OUT;
          res_id     = slot_id[0];
        end
      end
      default: begin
        res_status = STAT_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      time_now      <= '0;
      timeout_ticks <= TimeoutReset;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_ticks <= cfg_data;
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
        if (do_tick) time_now <= time_inc;
        if (do_post) begin
          count <= count + CntW'(1);
        end else if (remove) begin
          count <= count - CntW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= req_t'(in_req);
      id  <= in_id;
    end
    if (cmd.exec) begin
      out_status <= res_status;
      out_id     <= res_id;
      if (do_post) begin
        slot_id[count[IdxW-1:0]]       <= id;
        slot_deadline[count[IdxW-1:0]] <= time_now + timeout_ticks;
      end
      if (remove) begin
        // close the gap: entries behind the removed one move up
        for (int k = 0; k < TableDepth - 1; k++) begin
          if (IdxW'(k) >= remove_pos) begin
            slot_id[k]       <= slot_id[k+1];
            slot_deadline[k] <= slot_deadline[k+1];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/outstanding_transaction_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// outstanding_transaction_tracker_top
// Ordered table of pending transactions with per-entry deadlines.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | tuser req_type, tdata trans_id
//  m_      | out       | m_tvalid/m_tready  | tuser status, tdata result_id
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_data timeout_ticks
//
//  Each transaction is captured in the WAIT state; the EXEC state then runs the
//  lookup, shift and update of the 16-slot table in a single step.
//  The EXEC state waits while a previous result is held by m_tready low.
//  Reset empties the table, clears time and loads timeout_ticks with 1000.
// ----------------------------------------------------------------------------
module outstanding_transaction_tracker_top import ott_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [1:0]          s_tuser,   // [1:0] req_type
  input  wire logic [31:0]         s_tdata,   // [31:0] trans_id
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [2:0]               m_tuser,   // [2:0] status
  output logic [31:0]              m_tdata,   // [31:0] result_id
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [31:0]         cfg_data   // [31:0] timeout_ticks
);

  ott_cmd_t  cmd;
  ott_stat_t stat;

  assign cfg_ready = 1'b1;

  ott_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ott_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (s_tuser),
    .in_id      (s_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_id     (m_tdata)
  );

endmodule
`default_nettype wire
